[src/mpd_pkg.sv]
// Shared types, codes and exponent tables of the meter packet decoder.
`timescale 1ns / 1ps

package mpd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [3:0] LAST_POS  = 4'd8;

    localparam logic [15:0] READING_LIMIT_RST = 16'd6000;
    localparam logic [15:0] DIODE_LIMIT_RST   = 16'd2500;

    // Configuration register indexes
    localparam logic CFG_READING_LIMIT = 1'b0;
    localparam logic CFG_DIODE_LIMIT   = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVER    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NA      = 2'd3;

    // Quantity codes
    localparam logic [2:0] QTY_VOLTAGE     = 3'd0;
    localparam logic [2:0] QTY_CURRENT     = 3'd1;
    localparam logic [2:0] QTY_RESISTANCE  = 3'd2;
    localparam logic [2:0] QTY_FREQUENCY   = 3'd3;
    localparam logic [2:0] QTY_CAPACITANCE = 3'd4;
    localparam logic [2:0] QTY_CONTINUITY  = 3'd5;
    localparam logic [2:0] QTY_DUTY        = 3'd6;

    // Unit codes
    localparam logic [2:0] UNIT_VOLT    = 3'd0;
    localparam logic [2:0] UNIT_AMPERE  = 3'd1;
    localparam logic [2:0] UNIT_OHM     = 3'd2;
    localparam logic [2:0] UNIT_HERTZ   = 3'd3;
    localparam logic [2:0] UNIT_FARAD   = 3'd4;
    localparam logic [2:0] UNIT_BOOLEAN = 3'd5;
    localparam logic [2:0] UNIT_PERCENT = 3'd6;

    // Meter mode codes
    localparam logic [2:0] MODE_CURRENT_A  = 3'd0;
    localparam logic [2:0] MODE_CURRENT_B  = 3'd1;
    localparam logic [2:0] MODE_VOLTAGE    = 3'd2;
    localparam logic [2:0] MODE_DIODE      = 3'd3;
    localparam logic [2:0] MODE_RESISTANCE = 3'd4;
    localparam logic [2:0] MODE_FARADS     = 3'd5;
    localparam logic [2:0] MODE_FREQ       = 3'd6;

    typedef struct packed {
        logic [7:0]  mode_byte;
        logic [7:0]  range_byte;
        logic [7:0]  freq_byte;
        logic [15:0] main_raw;
        logic [15:0] sub_raw;
        logic [7:0]  flag_byte;
    } pkt_t;

    typedef struct packed {
        logic               display_sel;
        logic [1:0]         status;
        logic [2:0]         quantity;
        logic [2:0]         unit;
        logic signed [16:0] reading;
        logic signed [4:0]  exponent;
        logic               is_ac;
        logic               is_dc;
        logic               is_auto;
        logic               diode_test;
        logic               last;
    } res_t;

    function automatic logic signed [4:0] volt_exp(input logic [2:0] r);
        logic signed [4:0] e;
        case (r)
            3'd0:    e = -5'sd4;
            3'd1:    e = -5'sd3;
            3'd2:    e = -5'sd2;
            3'd3:    e = -5'sd1;
            default: e = 5'sd0;
        endcase
        return e;
    endfunction

    function automatic logic signed [4:0] ohm_exp(input logic [2:0] r);
        logic signed [4:0] e;
        case (r)
            3'd0:    e = -5'sd1;
            3'd1:    e = 5'sd0;
            3'd2:    e = 5'sd1;
            3'd3:    e = 5'sd2;
            3'd4:    e = 5'sd3;
            default: e = 5'sd4;
        endcase
        return e;
    endfunction

    function automatic logic signed [4:0] farad_exp(input logic [2:0] r);
        logic signed [4:0] e;
        e = -5'sd12 + $signed({2'b00, r});
        return e;
    endfunction

    function automatic logic signed [4:0] freq_exp(input logic [2:0] r);
        logic signed [4:0] e;
        e = -5'sd2 + $signed({2'b00, r});
        return e;
    endfunction

endpackage

[src/mpd_collect.sv]
// Sync hunt and packet byte collection.
`timescale 1ns / 1ps

module mpd_collect
    import mpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       at_last,
    output logic       done,
    output pkt_t       pkt
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] bytes_reg [0:6];

    assign at_last = (pos_reg == LAST_POS);
    assign done    = accept && at_last;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == 4'd0)
            begin
                if (rx_byte == SYNC_BYTE)
                    pos_next = 4'd1;
            end
            else if (at_last)
                pos_next = 4'd0;
            else
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 4'd0;
        else
            pos_reg <= pos_next;
    end

    // Flag byte is taken straight from the completing item
    always_ff @(posedge clk)
    begin
        if (accept && pos_reg != 4'd0 && !at_last)
            bytes_reg[3'(pos_reg - 4'd1)] <= rx_byte;
    end

    assign pkt.mode_byte  = bytes_reg[0];
    assign pkt.range_byte = bytes_reg[1];
    assign pkt.freq_byte  = bytes_reg[2];
    assign pkt.main_raw   = {bytes_reg[4], bytes_reg[3]};
    assign pkt.sub_raw    = {bytes_reg[6], bytes_reg[5]};
    assign pkt.flag_byte  = rx_byte;

endmodule

[src/mpd_decode.sv]
// Decode of one display of a completed packet.
`timescale 1ns / 1ps

module mpd_decode
    import mpd_pkg::*;
(
    input  logic        sub,
    input  pkt_t        pkt,
    input  logic [15:0] reading_limit,
    input  logic [15:0] diode_limit,
    output res_t        res
);

    logic [2:0]         mode;
    logic               func;
    logic [2:0]         range;
    logic [2:0]         frange;
    logic               bad;
    logic               na;
    logic [2:0]         qty;
    logic [2:0]         unt;
    logic signed [4:0]  ex;
    logic               sgn;
    logic               ac;
    logic               dc;
    logic               autor;
    logic               diode;
    logic               beep;
    logic [15:0]        raw;
    logic [15:0]        lim;
    logic signed [16:0] val;
    logic [16:0]        mag;
    logic               over;

    assign mode   = pkt.mode_byte[2:0];
    assign func   = pkt.mode_byte[3];
    assign range  = pkt.range_byte[2:0];
    assign frange = pkt.freq_byte[2:0];

    always_comb
    begin
        bad   = 1'b0;
        na    = 1'b0;
        qty   = QTY_VOLTAGE;
        unt   = UNIT_VOLT;
        ex    = 5'sd0;
        sgn   = 1'b0;
        ac    = 1'b0;
        dc    = 1'b0;
        autor = 1'b0;
        diode = 1'b0;
        beep  = 1'b0;
        lim   = reading_limit;
        raw   = pkt.main_raw;
        if (!sub)
        begin
            autor = !pkt.flag_byte[0];
            unique case (mode)
                MODE_CURRENT_A, MODE_CURRENT_B:
                begin
                    ex  = (mode == MODE_CURRENT_A) ? -5'sd1 : -5'sd2;
                    qty = QTY_CURRENT;
                    unt = UNIT_AMPERE;
                    sgn = 1'b1;
                    dc  = func;
                    ac  = !func;
                end
                MODE_VOLTAGE:
                begin
                    bad = (range >= 3'd5);
                    ex  = volt_exp(range);
                    sgn = 1'b1;
                    dc  = func;
                    ac  = !func;
                end
                MODE_DIODE:
                begin
                    if (func)
                    begin
                        ex    = -5'sd3;
                        lim   = diode_limit;
                        diode = 1'b1;
                        dc    = 1'b1;
                    end
                    else
                    begin
                        beep = 1'b1;
                        qty  = QTY_CONTINUITY;
                        unt  = UNIT_BOOLEAN;
                    end
                end
                MODE_RESISTANCE:
                begin
                    bad = (range >= 3'd6);
                    ex  = ohm_exp(range);
                    qty = QTY_RESISTANCE;
                    unt = UNIT_OHM;
                end
                MODE_FARADS:
                begin
                    ex  = farad_exp(range);
                    qty = QTY_CAPACITANCE;
                    unt = UNIT_FARAD;
                end
                MODE_FREQ:
                begin
                    bad = (frange == 3'd7);
                    ex  = freq_exp(frange);
                    qty = QTY_FREQUENCY;
                    unt = UNIT_HERTZ;
                end
                default:
                    bad = 1'b1;
            endcase
        end
        else
        begin
            raw = pkt.sub_raw;
            if (mode <= MODE_VOLTAGE && !func)
            begin
                qty = QTY_FREQUENCY;
                unt = UNIT_HERTZ;
                ex  = -5'sd2;
            end
            else if (mode == MODE_FREQ)
            begin
                qty = QTY_DUTY;
                unt = UNIT_PERCENT;
                ex  = -5'sd1;
            end
            else
                na = 1'b1;
        end
    end

    assign val  = sgn ? $signed({raw[15], raw}) : $signed({1'b0, raw});
    assign mag  = val[16] ? 17'(-val) : 17'(val);
    assign over = (mag > {1'b0, lim});

    always_comb
    begin
        res             = '0;
        res.display_sel = sub;
        res.last        = sub;
        if (bad)
            res.status = ST_INVALID;
        else if (na)
            res.status = ST_NA;
        else
        begin
            res.status     = over ? ST_OVER : ST_OK;
            res.quantity   = qty;
            res.unit       = unt;
            res.exponent   = ex;
            res.is_ac      = ac;
            res.is_dc      = dc;
            res.is_auto    = autor;
            res.diode_test = diode;
            if (beep)
                res.reading = over ? 17'sd0 : 17'sd1;
            else
                res.reading = val;
        end
    end

endmodule

[src/mpd_outq.sv]
// Four-entry result queue, two items pushed per packet, one popped per cycle while out_ready is high.
`timescale 1ns / 1ps

module mpd_outq
    import mpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t main_res,
    input  res_t sub_res,
    output logic room2,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    res_t       mem_reg [0:3];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd2 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + (push ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg]        <= main_res;
            mem_reg[wr_ptr_reg + 2'd1] <= sub_res;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg <= 3'd2)
        else $error("packet pushed without room for two items");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("queue count beyond depth");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 3'd2)
        else $error("queue count did not grow by two");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 3'd4 |-> 2'(wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("queue pointers disagree with count");

endmodule

[src/multimeter_packet_decoder_top.sv]
// Top level: meter byte stream in, main and sub display results out.
// Results of a packet are registered into the result queue when its ninth byte is accepted.
// Throughput: one byte per cycle unless the ninth byte is held back; each packet yields two items, main then sub.
// The four-entry result queue holds back the ninth byte only while under two entries are free.
// Reset (rst_n low, asynchronous) returns to the sync hunt, empties the queue
// and loads the limits with 6000 and 2500.
`timescale 1ns / 1ps

module multimeter_packet_decoder_top
    import mpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], quantity[4:2], unit[7:5], reading[24:8], exponent[29:25],
    // is_ac[30], is_dc[31], is_auto[32], diode_test[33], zero[39:34]
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // display_sel[0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] reading_limit_reg;
    logic [15:0] diode_limit_reg;
    logic        accept;
    logic        at_last;
    logic        done;
    logic        room2;
    pkt_t        pkt;
    res_t        main_res;
    res_t        sub_res;
    res_t        out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_limit_reg <= READING_LIMIT_RST;
            diode_limit_reg   <= DIODE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_READING_LIMIT: reading_limit_reg <= cfg_wdata;
                CFG_DIODE_LIMIT:   diode_limit_reg   <= cfg_wdata;
                default:           reading_limit_reg <= reading_limit_reg;
            endcase
        end
    end

    // Stall only the packet-completing item when the queue is short of room
    assign s_tready = !at_last || room2;
    assign accept   = s_tvalid && s_tready;

    mpd_collect u_collect (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .at_last (at_last),
        .done    (done),
        .pkt     (pkt)
    );

    mpd_decode u_dec_main (
        .sub           (1'b0),
        .pkt           (pkt),
        .reading_limit (reading_limit_reg),
        .diode_limit   (diode_limit_reg),
        .res           (main_res)
    );

    mpd_decode u_dec_sub (
        .sub           (1'b1),
        .pkt           (pkt),
        .reading_limit (reading_limit_reg),
        .diode_limit   (diode_limit_reg),
        .res           (sub_res)
    );

    mpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (done),
        .main_res  (main_res),
        .sub_res   (sub_res),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.diode_test, out_res.is_auto, out_res.is_dc, out_res.is_ac,
                      out_res.exponent, out_res.reading, out_res.unit, out_res.quantity,
                      out_res.status};
    assign m_tuser = out_res.display_sel;
    assign m_tlast = out_res.last;

endmodule
